>>> hw/rtl/gshbtb_pkg.sv
// ----------------------------------------------------------------------------
// Gshare predictor package
// Shared widths, codes and structures for the gshare predictor and its BTB.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gshbtb_pkg;

   // Sizes of the history, the counter table and the target buffer.
   localparam int HISTORY_BITS   = 8;
   localparam int BTB_INDEX_BITS = 10;
   localparam int PHT_DEPTH      = 1 << HISTORY_BITS;
   localparam int BTB_DEPTH      = 1 << BTB_INDEX_BITS;
   localparam int PC_WIDTH       = 64;
   localparam int CTR_WIDTH      = 2;

   // Counter thresholds and the sequential fetch step.
   localparam logic [CTR_WIDTH-1:0] CTR_MAX       = 2'd3;
   localparam logic [CTR_WIDTH-1:0] CTR_MIN       = 2'd0;
   localparam logic [CTR_WIDTH-1:0] CTR_TAKEN_MIN = 2'd2;
   localparam logic [PC_WIDTH-1:0]  PC_STEP       = 64'd4;

   // Request operation codes.
   typedef enum logic {
      OP_PREDICT = 1'b0,
      OP_UPDATE  = 1'b1
   } op_type;

   // One target buffer entry.
   typedef struct packed {
      logic                valid;
      logic                cond;
      logic [PC_WIDTH-1:0] tag;
      logic [PC_WIDTH-1:0] target;
   } btb_entry_type;

   // Write port of the counter table.
   typedef struct packed {
      logic                    en;
      logic [HISTORY_BITS-1:0] idx;
      logic [CTR_WIDTH-1:0]    ctr;
   } pht_wr_type;

   // Write port of the target buffer.
   typedef struct packed {
      logic                      en;
      logic [BTB_INDEX_BITS-1:0] idx;
      btb_entry_type             entry;
   } btb_wr_type;

endpackage

`default_nettype wire

>>> hw/rtl/gshbtb_pht.sv
// ----------------------------------------------------------------------------
// Gshare counter table
// Two-bit counter memory with per-entry written bits and write forwarding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gshbtb_pht (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 rd_en,
   input  wire logic [gshbtb_pkg::HISTORY_BITS-1:0]  rd_idx,
   input  wire gshbtb_pkg::pht_wr_type               wr,
   output logic      [gshbtb_pkg::CTR_WIDTH-1:0]     rd_ctr
);
   import gshbtb_pkg::*;

   logic [CTR_WIDTH-1:0] mem [PHT_DEPTH];
   logic [PHT_DEPTH-1:0] written_ff;
   logic [CTR_WIDTH-1:0] rd_ff;
   logic                 rd_written_ff;
   logic                 fwd_hit_ff;
   logic [CTR_WIDTH-1:0] fwd_ctr_ff;

   // An entry never written reads as zero, which is its reset value.
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr.en) begin
         written_ff[wr.idx] <= 1'b1;
      end
   end

   // Memory array with registered read. A write at the same edge as the
   // read is captured so that the reader sees the newest value.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.idx] <= wr.ctr;
      end
      if (rd_en) begin
         rd_ff         <= mem[rd_idx];
         rd_written_ff <= written_ff[rd_idx];
         fwd_hit_ff    <= wr.en && (wr.idx == rd_idx);
         fwd_ctr_ff    <= wr.ctr;
      end
   end

   // Select the forwarded, stored or reset value.
   always_comb begin
      if (fwd_hit_ff) begin
         rd_ctr = fwd_ctr_ff;
      end else if (rd_written_ff) begin
         rd_ctr = rd_ff;
      end else begin
         rd_ctr = CTR_MIN;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/gshbtb_btb.sv
// ----------------------------------------------------------------------------
// Branch target buffer
// Direct-mapped entry memory with a valid-clearing sweep after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gshbtb_btb (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  rd_en,
   input  wire logic [gshbtb_pkg::BTB_INDEX_BITS-1:0] rd_idx,
   input  wire gshbtb_pkg::btb_wr_type                wr,
   output gshbtb_pkg::btb_entry_type                  rd_entry,
   output logic                                       busy
);
   import gshbtb_pkg::*;

   btb_entry_type             mem [BTB_DEPTH];
   btb_entry_type             rd_ff;
   logic                      fwd_hit_ff;
   btb_entry_type             fwd_entry_ff;
   logic                      clr_ff;
   logic [BTB_INDEX_BITS-1:0] clr_idx_ff;
   btb_wr_type                port;

   // Clearing sweep: one entry per cycle from reset until the last index.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_idx_ff <= '0;
      end else if (clr_ff) begin
         clr_idx_ff <= clr_idx_ff + 1'b1;
         if (clr_idx_ff == {BTB_INDEX_BITS{1'b1}}) begin
            clr_ff <= 1'b0;
         end
      end
   end

   // The sweep owns the write port while it runs.
   always_comb begin
      if (clr_ff) begin
         port.en    = 1'b1;
         port.idx   = clr_idx_ff;
         port.entry = '0;
      end else begin
         port = wr;
      end
   end

   // Memory array with registered read and same-edge write capture.
   always_ff @(posedge clock) begin
      if (port.en) begin
         mem[port.idx] <= port.entry;
      end
      if (rd_en) begin
         rd_ff        <= mem[rd_idx];
         fwd_hit_ff   <= port.en && (port.idx == rd_idx);
         fwd_entry_ff <= port.entry;
      end
   end

   assign rd_entry = fwd_hit_ff ? fwd_entry_ff : rd_ff;
   assign busy     = clr_ff;

endmodule

`default_nettype wire

>>> hw/rtl/gshbtb_core.sv
// ----------------------------------------------------------------------------
// Gshare predictor datapath
// Forms the prediction and the training writes for the item in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gshbtb_core (
   input  wire logic                                 is_update,
   input  wire logic                                 cond,
   input  wire logic                                 taken,
   input  wire logic [gshbtb_pkg::PC_WIDTH-1:0]      pc,
   input  wire logic [gshbtb_pkg::PC_WIDTH-1:0]      target,
   input  wire logic [gshbtb_pkg::HISTORY_BITS-1:0]  hidx,
   input  wire logic [gshbtb_pkg::HISTORY_BITS-1:0]  hist,
   input  wire logic                                 advance,
   input  wire logic [gshbtb_pkg::CTR_WIDTH-1:0]     ctr,
   input  wire gshbtb_pkg::btb_entry_type            entry,
   output logic      [gshbtb_pkg::PC_WIDTH-1:0]      next_pc,
   output logic                                      miss,
   output logic      [gshbtb_pkg::HISTORY_BITS-1:0]  hist_next,
   output gshbtb_pkg::pht_wr_type                    pht_wr,
   output gshbtb_pkg::btb_wr_type                    btb_wr
);
   import gshbtb_pkg::*;

   logic                 hit;
   logic                 train;
   logic [CTR_WIDTH-1:0] ctr_new;

   assign hit   = entry.valid && (entry.tag == pc);
   assign train = advance && is_update && cond;

   // Prediction: stored target on a hit that is unconditional or leans taken.
   always_comb begin
      miss = !hit;
      if (hit && ((ctr >= CTR_TAKEN_MIN) || !entry.cond)) begin
         next_pc = entry.target;
      end else begin
         next_pc = pc + PC_STEP;
      end
   end

   // Saturating counter step for a resolved conditional branch.
   always_comb begin
      ctr_new = ctr;
      if (taken && (ctr != CTR_MAX)) begin
         ctr_new = ctr + 1'b1;
      end else if (!taken && (ctr != CTR_MIN)) begin
         ctr_new = ctr - 1'b1;
      end
   end

   // Training writes and the shifted history.
   always_comb begin
      hist_next  = train ? {hist[HISTORY_BITS-2:0], taken} : hist;
      pht_wr.en  = train;
      pht_wr.idx = hidx;
      pht_wr.ctr = ctr_new;

      btb_wr.en           = advance && is_update;
      btb_wr.idx          = pc[BTB_INDEX_BITS+1:2];
      btb_wr.entry.valid  = 1'b1;
      btb_wr.entry.cond   = hit ? entry.cond : cond;
      btb_wr.entry.tag    = pc;
      btb_wr.entry.target = target;
   end

endmodule

`default_nettype wire

>>> hw/rtl/gshbtb_top_stub.sv
// ----------------------------------------------------------------------------
// Gshare history register
// Global branch history, shifted by each resolved conditional branch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gshbtb_top_stub (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [gshbtb_pkg::HISTORY_BITS-1:0] hist_in,
   output logic      [gshbtb_pkg::HISTORY_BITS-1:0] hist_ff
);
   import gshbtb_pkg::*;

   // History register, cleared at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
      end else begin
         hist_ff <= hist_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/gshare_predictor_with_btb.sv
// ----------------------------------------------------------------------------
// Gshare branch predictor with branch target buffer
// Top level: request register, memories, datapath and response register.
// ----------------------------------------------------------------------------
// The block takes one request per cycle, predict or update, unless it
// stalls; a predict request's response reaches the response register by way
// of the request register. Both tables are read at the accepting edge with
// registered read data, and the writes of an update are forwarded to the
// request that follows it, so back-to-back requests see each other's effects.
// A new request waits while the target buffer is being cleared, and else only
// while a predict request ahead of it is held because the response register
// is full and stalled; an update request never holds the request register.
// After reset the target buffer clears its valid bits one entry per cycle.
`timescale 1ns / 1ps
`default_nettype none

module gshare_predictor_with_btb (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_op,
   input  wire logic [gshbtb_pkg::PC_WIDTH-1:0]      req_pc,
   input  wire logic                                 req_is_conditional,
   input  wire logic                                 req_taken,
   input  wire logic [gshbtb_pkg::PC_WIDTH-1:0]      req_target,
   input  wire logic [gshbtb_pkg::HISTORY_BITS-1:0]  req_history_index,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic      [gshbtb_pkg::PC_WIDTH-1:0]      rsp_next_pc,
   output logic                                      rsp_lookup_miss,
   output logic      [gshbtb_pkg::HISTORY_BITS-1:0]  rsp_pred_index
);
   import gshbtb_pkg::*;

   // Request register.
   logic                    s1_valid_ff;
   logic                    s1_valid_in;
   logic                    s1_update_ff;
   logic                    s1_cond_ff;
   logic                    s1_taken_ff;
   logic [PC_WIDTH-1:0]     s1_pc_ff;
   logic [PC_WIDTH-1:0]     s1_target_ff;
   logic [HISTORY_BITS-1:0] s1_hidx_ff;
   logic [HISTORY_BITS-1:0] s1_pidx_ff;

   // Response register.
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [PC_WIDTH-1:0]     rsp_pc_ff;
   logic                    rsp_miss_ff;
   logic [HISTORY_BITS-1:0] rsp_idx_ff;

   logic                    accept;
   logic                    s1_adv;
   logic                    out_free;
   logic                    busy;
   logic [HISTORY_BITS-1:0] hist_ff;
   logic [HISTORY_BITS-1:0] hist_in;
   logic [HISTORY_BITS-1:0] pred_idx;
   logic [HISTORY_BITS-1:0] pht_rd_idx;
   logic [CTR_WIDTH-1:0]    ctr;
   btb_entry_type           entry;
   pht_wr_type              pht_wr;
   btb_wr_type              btb_wr;
   logic [PC_WIDTH-1:0]     next_pc;
   logic                    miss;

   // Handshake and pipeline advance.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_adv    = s1_valid_ff && (s1_update_ff || out_free);
   assign req_stall = busy || (s1_valid_ff && !s1_adv);
   assign accept    = req_valid && !req_stall;

   // The index uses the history as the request ahead of it leaves it.
   assign pred_idx   = req_pc[HISTORY_BITS+1:2] ^ hist_in;
   assign pht_rd_idx = (req_op == OP_UPDATE) ? req_history_index : pred_idx;

   gshbtb_pht u_pht (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (accept),
      .rd_idx (pht_rd_idx),
      .wr     (pht_wr),
      .rd_ctr (ctr)
   );

   gshbtb_btb u_btb (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_idx   (req_pc[BTB_INDEX_BITS+1:2]),
      .wr       (btb_wr),
      .rd_entry (entry),
      .busy     (busy)
   );

   gshbtb_core u_core (
      .is_update (s1_update_ff),
      .cond      (s1_cond_ff),
      .taken     (s1_taken_ff),
      .pc        (s1_pc_ff),
      .target    (s1_target_ff),
      .hidx      (s1_hidx_ff),
      .hist      (hist_ff),
      .advance   (s1_adv),
      .ctr       (ctr),
      .entry     (entry),
      .next_pc   (next_pc),
      .miss      (miss),
      .hist_next (hist_in),
      .pht_wr    (pht_wr),
      .btb_wr    (btb_wr)
   );

   gshbtb_top_stub u_hist (
      .clock   (clock),
      .reset   (reset),
      .hist_in (hist_in),
      .hist_ff (hist_ff)
   );

   // Control next values.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s1_adv && !s1_update_ff) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request payload register.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_update_ff <= (req_op == OP_UPDATE);
         s1_cond_ff   <= req_is_conditional;
         s1_taken_ff  <= req_taken;
         s1_pc_ff     <= req_pc;
         s1_target_ff <= req_target;
         s1_hidx_ff   <= req_history_index;
         s1_pidx_ff   <= pred_idx;
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (s1_adv && !s1_update_ff) begin
         rsp_pc_ff   <= next_pc;
         rsp_miss_ff <= miss;
         rsp_idx_ff  <= s1_pidx_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_next_pc     = rsp_pc_ff;
   assign rsp_lookup_miss = rsp_miss_ff;
   assign rsp_pred_index  = rsp_idx_ff;

   // No request is taken while the target buffer is being cleared.
   a_no_accept_in_clear : assert property (@(posedge clock) disable iff (reset)
      busy |-> !accept)
      else $error("request accepted during target buffer clear");

   // An update request in flight always leaves in the next cycle.
   a_update_advances : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_update_ff) |-> s1_adv)
      else $error("update request held in the request register");

   // A stalled response is never overwritten by a new prediction.
   a_rsp_not_overwritten : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !(s1_adv && !s1_update_ff))
      else $error("pending response overwritten");

   // The history moves only on a resolved conditional branch.
   a_hist_stable : assert property (@(posedge clock) disable iff (reset)
      !pht_wr.en |=> $stable(hist_ff))
      else $error("history changed without a conditional update");

endmodule

`default_nettype wire
